@@ sv/tfarf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-format ALU register file package
// Shared types and constants for the instruction decode and the ALU.
// ----------------------------------------------------------------------------
package tfarf_pkg;

   localparam int unsigned DATA_W = 16;
   localparam int unsigned INSTR_W = 16;
   localparam int unsigned REG_CNT = 8;
   localparam int unsigned IDX_W = 3;
   localparam int unsigned IMM_W = 8;
   localparam int unsigned SHAMT_W = 4;

   typedef logic [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_AND = 3'd2,
      OP_OR  = 3'd3,
      OP_XOR = 3'd4,
      OP_SHL = 3'd5,
      OP_SHR = 3'd6,
      OP_CMP = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      FMT_REG  = 2'd0,
      FMT_IMM  = 2'd1,
      FMT_NOP2 = 2'd2,
      FMT_NOP3 = 2'd3
   } fmt_type;

   localparam data_type CMP_EQUAL = 16'h0000;
   localparam data_type CMP_GREATER = 16'h0001;
   localparam data_type CMP_LESS = 16'h0002;

endpackage

@@ sv/tfarf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-format ALU register file channels
// Valid/ready channels for the instruction word and the result word.
// ----------------------------------------------------------------------------
interface tfarf_req_if;
   logic valid;
   logic ready;
   logic [15:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface tfarf_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] dest_value;

   modport source (output valid, output dest_value, input ready);
   modport sink (input valid, input dest_value, output ready);
endinterface

@@ sv/tfarf_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-format ALU
// Eight operations on 16-bit operands, all wrapping to 16 bits.
// ----------------------------------------------------------------------------
module tfarf_alu
   import tfarf_pkg::*;
(
   input  data_type a,
   input  data_type b,
   input  op_type   op,
   output data_type y
);

   always_comb begin
      case (op)
         OP_ADD: y = a + b;
         OP_SUB: y = a - b;
         OP_AND: y = a & b;
         OP_OR: y = a | b;
         OP_XOR: y = a ^ b;
         OP_SHL: y = a << b[SHAMT_W-1:0];
         OP_SHR: y = a >> b[SHAMT_W-1:0];
         OP_CMP: begin
            if (a == b) begin
               y = CMP_EQUAL;
            end else if (a > b) begin
               y = CMP_GREATER;
            end else begin
               y = CMP_LESS;
            end
         end
         default: y = a;
      endcase
   end

endmodule

@@ sv/two_format_alu_register_file.sv @@
`timescale 1ns / 1ps
// Result: each instruction is registered for execute, then its result word for output.
// Throughput: one instruction per cycle when not stalled. The register file memory is
// read in the accept cycle and written in the execute cycle, with the last write forwarded.
// Reset: synchronous and active high; it clears the pipeline and marks all eight
// registers invalid, and an invalid register reads as zero.
// ----------------------------------------------------------------------------
// Two-format ALU register file
// Eight-entry register file with a read, execute and write-back pipeline.
// ----------------------------------------------------------------------------
module two_format_alu_register_file
   import tfarf_pkg::*;
(
   input logic clock,
   input logic reset,
   tfarf_req_if.sink req_ch,
   tfarf_rsp_if.source rsp_ch
);

   data_type rf_mem [REG_CNT];
   logic [REG_CNT-1:0] rf_vld_ff, rf_vld_in;

   data_type a_mem_ff, b_mem_ff;
   logic a_vld_ff, b_vld_ff;

   logic s1_valid_ff, s1_valid_in;
   logic [INSTR_W-1:0] s1_instr_ff;

   logic wb_valid_ff, wb_valid_in;
   idx_type wb_addr_ff;
   data_type wb_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   data_type rsp_data_ff;

   logic accept, advance, wr_en;
   idx_type req_rd, req_rs, s1_rd, s1_rs;
   fmt_type s1_fmt;
   op_type s1_op;
   data_type op_a, op_b, rs_val, alu_y, result;

   assign req_rd = req_ch.instruction[15:13];
   assign req_rs = req_ch.instruction[12:10];

   assign s1_rd = s1_instr_ff[15:13];
   assign s1_rs = s1_instr_ff[12:10];
   assign s1_fmt = fmt_type'(s1_instr_ff[1:0]);
   assign s1_op = op_type'(s1_instr_ff[4:2]);

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == s1_rd)) begin
         op_a = wb_data_ff;
      end else begin
         op_a = a_vld_ff ? a_mem_ff : '0;
      end
      if (wb_valid_ff && (wb_addr_ff == s1_rs)) begin
         rs_val = wb_data_ff;
      end else begin
         rs_val = b_vld_ff ? b_mem_ff : '0;
      end
      if (s1_fmt == FMT_REG) begin
         op_b = rs_val;
      end else begin
         op_b = {{(DATA_W-IMM_W){1'b0}}, s1_instr_ff[12:5]};
      end
   end

   tfarf_alu u_alu (
      .a(op_a),
      .b(op_b),
      .op(s1_op),
      .y(alu_y)
   );

   assign wr_en = advance && ((s1_fmt == FMT_REG) || (s1_fmt == FMT_IMM));
   assign result = ((s1_fmt == FMT_REG) || (s1_fmt == FMT_IMM)) ? alu_y : op_a;

   always_ff @(posedge clock) begin
      if (accept) begin
         a_mem_ff <= rf_mem[req_rd];
         b_mem_ff <= rf_mem[req_rs];
      end
      if (wr_en) begin
         rf_mem[s1_rd] <= alu_y;
      end
   end

   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (wr_en) begin
         rf_vld_in[s1_rd] = 1'b1;
      end
      s1_valid_in = accept || (s1_valid_ff && !advance);
      wb_valid_in = advance ? wr_en : wb_valid_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
         s1_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         rf_vld_ff <= rf_vld_in;
         s1_valid_ff <= s1_valid_in;
         wb_valid_ff <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            a_vld_ff <= rf_vld_ff[req_rd];
            b_vld_ff <= rf_vld_ff[req_rs];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_ch.instruction;
      end
      if (advance) begin
         wb_addr_ff <= s1_rd;
         wb_data_ff <= alu_y;
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dest_value = rsp_data_ff;

endmodule
